// ===== sv/register_dependency_hazard_counter_assert.svh =====
// assertion macros for the hazard counter checker
`ifndef REGISTER_DEPENDENCY_HAZARD_COUNTER_ASSERT_SVH
`define REGISTER_DEPENDENCY_HAZARD_COUNTER_ASSERT_SVH

// clocked on clk, off while arst_n is low
`define RDHC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition in this cycle implies property in the next
`define RDHC_ASSERT_NEXT(lbl, cond, prop, msg) \
	`RDHC_ASSERT(lbl, (cond) |=> (prop), msg)

`endif

// ===== sv/rdhc_pkg.sv =====
`default_nettype none
package rdhc_pkg;

	localparam int NUM_REGS      = 32;
	localparam int HAZARD_WINDOW = 3;
	localparam int FIELD_W       = 5;
	localparam int REG_W         = $clog2(NUM_REGS);
	localparam int CNT_W         = 32;
	localparam int WIN_CNT_W     = $clog2(HAZARD_WINDOW + 1);

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [REG_W-1:0]   reg_idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [WIN_CNT_W-1:0] win_cnt_t;

	localparam cnt_t CNT_MAX = '1;

	typedef struct packed {
		logic     en;
		reg_idx_t addr;
		cnt_t     data;
	} cnt_wr_t;

	typedef struct packed {
		logic     valid;
		reg_idx_t dest;
		reg_idx_t src_a;
		reg_idx_t src_b;
	} win_entry_t;

	function automatic reg_idx_t reg_of(field_t v);
		return REG_W'(v % NUM_REGS);
	endfunction

	function automatic cnt_t sat_inc(cnt_t x, logic inc);
		logic [CNT_W:0] s;
		s = {1'b0, x} + (CNT_W + 1)'(inc);
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	function automatic cnt_t sat_add3(cnt_t x, cnt_t y, cnt_t z);
		logic [CNT_W+1:0] s;
		s = {2'b00, x} + {2'b00, y} + {2'b00, z};
		return (s[CNT_W+1:CNT_W] != 2'b00) ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/register_dependency_hazard_counter.sv =====
// a taken word is registered into the compare stage, and its totals register when it commits
// throughput: one word per cycle unless out_stall holds the single compare and update stage
// count tables are read as a word is taken, with a one-word bypass for the word just committed
// reset (arst_n low, asynchronous) clears totals, window and table valid bits at once
// no clearing pass: the block takes words as soon as reset is released
`default_nettype none
module register_dependency_hazard_counter (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire rdhc_pkg::field_t      dest_reg,
	input  wire rdhc_pkg::field_t      src_a_reg,
	input  wire rdhc_pkg::field_t      src_b_reg,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output rdhc_pkg::cnt_t             true_dep_total,
	output rdhc_pkg::cnt_t             anti_dep_total,
	output rdhc_pkg::cnt_t             output_dep_total,
	output rdhc_pkg::cnt_t             raw_hazard_total,
	output rdhc_pkg::cnt_t             war_hazard_total,
	output rdhc_pkg::cnt_t             waw_hazard_total,
	output rdhc_pkg::cnt_t             items_seen
);

	logic accept;
	logic commit;

	rdhc_pkg::reg_idx_t d_in, a_in, b_in;

	logic                 vld_s1;
	rdhc_pkg::reg_idx_t   d_s1, a_s1, b_s1;
	rdhc_pkg::win_entry_t fwd_s1;
	logic                 out_valid_q;

	rdhc_pkg::win_entry_t win_q [rdhc_pkg::HAZARD_WINDOW];

	rdhc_pkg::cnt_t true_q, anti_q, outd_q, raw_q, war_q, waw_q, items_q;

	rdhc_pkg::cnt_t mw_a, mw_b, mw_d, mca_a, mca_d, mcb_b, mcb_d;
	rdhc_pkg::cnt_t wa_c, wb_c, wd_c, ca_a_c, ca_d_c, cb_b_c, cb_d_c;
	logic           fwd_b_new;

	rdhc_pkg::cnt_wr_t wr_w, wr_a, wr_b;

	rdhc_pkg::win_cnt_t raw_n, war_n, waw_n;

	assign d_in = rdhc_pkg::reg_of(dest_reg);
	assign a_in = rdhc_pkg::reg_of(src_a_reg);
	assign b_in = rdhc_pkg::reg_of(src_b_reg);

	assign commit   = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall = vld_s1 && !commit;
	assign accept   = in_valid && !in_stall;

	// writer counts, one copy per read address
	rdhc_cnt_ram u_wr_a (.clk, .arst_n, .wr(wr_w), .rd_en(accept), .rd_addr(a_in), .rd_data(mw_a));
	rdhc_cnt_ram u_wr_b (.clk, .arst_n, .wr(wr_w), .rd_en(accept), .rd_addr(b_in), .rd_data(mw_b));
	rdhc_cnt_ram u_wr_d (.clk, .arst_n, .wr(wr_w), .rd_en(accept), .rd_addr(d_in), .rd_data(mw_d));

	// reader counts split by first source and distinct second source
	rdhc_cnt_ram u_ca_a (.clk, .arst_n, .wr(wr_a), .rd_en(accept), .rd_addr(a_in), .rd_data(mca_a));
	rdhc_cnt_ram u_ca_d (.clk, .arst_n, .wr(wr_a), .rd_en(accept), .rd_addr(d_in), .rd_data(mca_d));
	rdhc_cnt_ram u_cb_b (.clk, .arst_n, .wr(wr_b), .rd_en(accept), .rd_addr(b_in), .rd_data(mcb_b));
	rdhc_cnt_ram u_cb_d (.clk, .arst_n, .wr(wr_b), .rd_en(accept), .rd_addr(d_in), .rd_data(mcb_d));

	// bypass for the word that committed at the edge the tables were read
	assign fwd_b_new = fwd_s1.src_b != fwd_s1.src_a;

	assign wa_c   = rdhc_pkg::sat_inc(mw_a, fwd_s1.valid && (fwd_s1.dest == a_s1));
	assign wb_c   = rdhc_pkg::sat_inc(mw_b, fwd_s1.valid && (fwd_s1.dest == b_s1));
	assign wd_c   = rdhc_pkg::sat_inc(mw_d, fwd_s1.valid && (fwd_s1.dest == d_s1));
	assign ca_a_c = rdhc_pkg::sat_inc(mca_a, fwd_s1.valid && (fwd_s1.src_a == a_s1));
	assign ca_d_c = rdhc_pkg::sat_inc(mca_d, fwd_s1.valid && (fwd_s1.src_a == d_s1));
	assign cb_b_c = rdhc_pkg::sat_inc(mcb_b,
		fwd_s1.valid && fwd_b_new && (fwd_s1.src_b == b_s1));
	assign cb_d_c = rdhc_pkg::sat_inc(mcb_d,
		fwd_s1.valid && fwd_b_new && (fwd_s1.src_b == d_s1));

	always_comb begin
		wr_w.en   = commit;
		wr_w.addr = d_s1;
		wr_w.data = rdhc_pkg::sat_inc(wd_c, 1'b1);
		wr_a.en   = commit;
		wr_a.addr = a_s1;
		wr_a.data = rdhc_pkg::sat_inc(ca_a_c, 1'b1);
		wr_b.en   = commit && (b_s1 != a_s1);
		wr_b.addr = b_s1;
		wr_b.data = rdhc_pkg::sat_inc(cb_b_c, 1'b1);
	end

	always_comb begin
		raw_n = '0;
		war_n = '0;
		waw_n = '0;
		for (int k = 0; k < rdhc_pkg::HAZARD_WINDOW; k++) begin
			if (win_q[k].valid) begin
				raw_n = raw_n + rdhc_pkg::WIN_CNT_W'((win_q[k].dest == a_s1) ||
					(win_q[k].dest == b_s1));
				war_n = war_n + rdhc_pkg::WIN_CNT_W'((win_q[k].src_a == d_s1) ||
					(win_q[k].src_b == d_s1));
				waw_n = waw_n + rdhc_pkg::WIN_CNT_W'(win_q[k].dest == d_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_s1         <= d_in;
			a_s1         <= a_in;
			b_s1         <= b_in;
			fwd_s1.valid <= commit;
			fwd_s1.dest  <= d_s1;
			fwd_s1.src_a <= a_s1;
			fwd_s1.src_b <= b_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			true_q      <= '0;
			anti_q      <= '0;
			outd_q      <= '0;
			raw_q       <= '0;
			war_q       <= '0;
			waw_q       <= '0;
			items_q     <= '0;
			for (int k = 0; k < rdhc_pkg::HAZARD_WINDOW; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (commit) begin
				vld_s1 <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				true_q  <= rdhc_pkg::sat_add3(true_q, wa_c, (b_s1 != a_s1) ? wb_c : '0);
				anti_q  <= rdhc_pkg::sat_add3(anti_q, ca_d_c, cb_d_c);
				outd_q  <= rdhc_pkg::sat_add3(outd_q, wd_c, '0);
				raw_q   <= rdhc_pkg::sat_add3(raw_q, rdhc_pkg::CNT_W'(raw_n), '0);
				war_q   <= rdhc_pkg::sat_add3(war_q, rdhc_pkg::CNT_W'(war_n), '0);
				waw_q   <= rdhc_pkg::sat_add3(waw_q, rdhc_pkg::CNT_W'(waw_n), '0);
				items_q <= rdhc_pkg::sat_inc(items_q, 1'b1);
				for (int k = rdhc_pkg::HAZARD_WINDOW - 1; k > 0; k--) begin
					win_q[k] <= win_q[k-1];
				end
				win_q[0].valid <= 1'b1;
				win_q[0].dest  <= d_s1;
				win_q[0].src_a <= a_s1;
				win_q[0].src_b <= b_s1;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign true_dep_total   = true_q;
	assign anti_dep_total   = anti_q;
	assign output_dep_total = outd_q;
	assign raw_hazard_total = raw_q;
	assign war_hazard_total = war_q;
	assign waw_hazard_total = waw_q;
	assign items_seen       = items_q;

endmodule
`default_nettype wire

// ===== sv/rdhc_cnt_ram.sv =====
`default_nettype none
module rdhc_cnt_ram (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rdhc_pkg::cnt_wr_t wr,
	input  wire logic              rd_en,
	input  wire rdhc_pkg::reg_idx_t rd_addr,
	output rdhc_pkg::cnt_t         rd_data
);

	rdhc_pkg::cnt_t                 mem_q [rdhc_pkg::NUM_REGS];
	logic [rdhc_pkg::NUM_REGS-1:0]  vld_q;
	rdhc_pkg::cnt_t                 data_q;
	logic                           hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			data_q <= mem_q[rd_addr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule
`default_nettype wire

// ===== sv/rdhc_checker.sv =====
`default_nettype none
`include "register_dependency_hazard_counter_assert.svh"
module rdhc_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           out_valid,
	input wire logic           out_stall,
	input wire rdhc_pkg::cnt_t true_dep_total,
	input wire rdhc_pkg::cnt_t raw_hazard_total,
	input wire rdhc_pkg::cnt_t items_seen
);

	`RDHC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(items_seen), "stalled word changed")
	`RDHC_ASSERT_NEXT(a_monotonic, 1'b1, (items_seen >= $past(items_seen)) && (true_dep_total >= $past(true_dep_total)), "total went down")
	`RDHC_ASSERT(a_raw_step, (items_seen == $past(items_seen) + 32'd1) |-> ((raw_hazard_total - $past(raw_hazard_total)) <= 32'd3), "window hazards grew by more than the window")
	`RDHC_ASSERT(a_quiet, ((items_seen == $past(items_seen)) && ($past(items_seen) != rdhc_pkg::CNT_MAX)) |-> ($stable(raw_hazard_total) && $stable(true_dep_total)), "totals moved without a new word")

endmodule

bind register_dependency_hazard_counter rdhc_checker u_rdhc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.true_dep_total   (true_dep_total),
	.raw_hazard_total (raw_hazard_total),
	.items_seen       (items_seen)
);
`default_nettype wire
